>>> sv/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  // Fixed widths of the transaction fields
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int OCC_W   = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_SEARCH     = 3'd4
  } kind_e;

  // What every cell of the chain does at each clock edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_LEFT,   // shift toward the back, cell 0 takes the pushed value
    CELL_TAKE_RIGHT,  // rotate toward the front
    CELL_LOAD         // the selected cell takes the pushed value
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } deq_state_e;

endpackage

>>> sv/double_ended_queue_core.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH values, DATA_WIDTH bits each.
// Input channel (in_valid_i/in_ready_o): kind_i selects push front, push back,
// pop front, pop back or search; value_i is the value to push or look for.
// Output channel (out_valid_o/out_ready_i): exactly one result per input
// transaction, in order: ok_o, found_o, popped_o and occupancy_o (count held
// after the request). Failed pushes/pops return ok_o = 0 and change nothing.
// Push front, push back, pop front and unused kinds take their result into the
// output register at the accepting edge. Pop back and search rotate the whole
// cell chain once around, one step per cycle, and load their result in
// ST_FINISH once the output register is free; the next transaction is taken
// only after the controller is back in ST_IDLE.
// A new transaction is taken only while no rotation runs and the output
// register is empty or being drained in the same cycle; a stalled receiver
// therefore holds off the input side.
// Reset empties the queue at once (count and control only); stored values
// are left as they are and never read until rewritten.
module double_ended_queue_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [deq_pkg::KIND_W-1:0]           kind_i,
  input  logic signed [deq_pkg::VALUE_W-1:0]   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 ok_o,
  output logic                                 found_o,
  output logic signed [deq_pkg::VALUE_W-1:0]   popped_o,
  output logic [deq_pkg::OCC_W-1:0]            occupancy_o
);
  import deq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [63:0]           val_ext;
  logic [DATA_WIDTH-1:0] val_dw;
  logic [DATA_WIDTH-1:0] popped_dw;
  logic [63:0]           pop_ext;
  logic [CNT_W-1:0]      occ;
  logic [CNT_W-1:0]      count;
  cell_op_e              cell_op;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] left_w    [DEPTH];
  logic [DATA_WIDTH-1:0] right_w   [DEPTH];
  logic                  sel_w     [DEPTH];

  // Values are kept in their low DATA_WIDTH bits, zero extended
  assign val_ext = 64'(unsigned'(value_i));
  assign val_dw  = val_ext[DATA_WIDTH-1:0];

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .value_i     (val_dw),
    .head_i      (cell_data[0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .found_o     (found_o),
    .popped_o    (popped_dw),
    .occ_o       (occ),
    .count_o     (count),
    .cell_op_o   (cell_op)
  );

  // Cell 0 is the front. Cells 0..count-1 hold the queue in order.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_w[i] = val_dw;
    end else begin : g_body
      assign left_w[i] = cell_data[i-1];
    end
    assign right_w[i] = cell_data[(i + 1) % DEPTH];
    // push back lands in the first free cell
    assign sel_w[i]   = (count == CNT_W'(i));

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .sel_i   (sel_w[i]),
      .left_i  (left_w[i]),
      .right_i (right_w[i]),
      .load_i  (val_dw),
      .data_o  (cell_data[i])
    );
  end

  assign pop_ext     = 64'(popped_dw);
  assign popped_o    = signed'(pop_ext[VALUE_W-1:0]);
  assign occupancy_o = OCC_W'(occ);

endmodule

>>> sv/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  deq_pkg::cell_op_e     op_i,
  input  logic                  sel_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] load_i,
  output logic [DATA_WIDTH-1:0] data_o
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    unique case (op_i)
      CELL_HOLD:       data_d = data_q;
      CELL_TAKE_LEFT:  data_d = left_i;
      CELL_TAKE_RIGHT: data_d = right_i;
      CELL_LOAD:       data_d = sel_i ? load_i : data_q;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> sv/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [deq_pkg::KIND_W-1:0]   kind_i,
  input  logic [DATA_WIDTH-1:0]        value_i,
  input  logic [DATA_WIDTH-1:0]        head_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         ok_o,
  output logic                         found_o,
  output logic [DATA_WIDTH-1:0]        popped_o,
  output logic [CNT_W-1:0]             occ_o,
  output logic [CNT_W-1:0]             count_o,
  output deq_pkg::cell_op_e            cell_op_o
);
  import deq_pkg::*;

  deq_state_e state_q, state_d;

  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      step_q, step_d;
  logic                  hit_q, hit_d;
  logic [DATA_WIDTH-1:0] grab_q, grab_d;
  logic [DATA_WIDTH-1:0] target_q;
  logic                  pop_back_q;

  logic                  out_valid_q, out_valid_d;
  logic                  res_load;
  logic                  res_ok_q, res_ok_d;
  logic                  res_found_q, res_found_d;
  logic [DATA_WIDTH-1:0] res_popped_q, res_popped_d;
  logic [CNT_W-1:0]      res_occ_q;

  logic out_free, accept, full, empty, scan_kind, in_window, at_back;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign scan_kind  = (kind_i == KIND_POP_BACK) || (kind_i == KIND_SEARCH);
  // head_i holds logical entry step_q while scanning
  assign in_window  = (CNT_W'(step_q) < count_q);
  assign at_back    = !empty && (CNT_W'(step_q) == count_q - CNT_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && scan_kind) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step_q == IDX_W'(DEPTH - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    cell_op_o    = CELL_HOLD;
    count_d      = count_q;
    step_d       = step_q;
    hit_d        = hit_q;
    grab_d       = grab_q;
    res_load     = 1'b0;
    res_ok_d     = 1'b0;
    res_found_d  = 1'b0;
    res_popped_d = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          step_d = '0;
          hit_d  = 1'b0;
          grab_d = '0;
          unique case (kind_i)
            KIND_PUSH_FRONT: begin
              res_load = 1'b1;
              if (!full) begin
                cell_op_o = CELL_TAKE_LEFT;
                count_d   = count_q + CNT_W'(1);
                res_ok_d  = 1'b1;
              end
            end
            KIND_PUSH_BACK: begin
              res_load = 1'b1;
              if (!full) begin
                cell_op_o = CELL_LOAD;
                count_d   = count_q + CNT_W'(1);
                res_ok_d  = 1'b1;
              end
            end
            KIND_POP_FRONT: begin
              res_load = 1'b1;
              if (!empty) begin
                cell_op_o    = CELL_TAKE_RIGHT;
                count_d      = count_q - CNT_W'(1);
                res_ok_d     = 1'b1;
                res_popped_d = head_i;
              end
            end
            KIND_POP_BACK, KIND_SEARCH: begin
              // handled by the rotation scan
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        cell_op_o = CELL_TAKE_RIGHT;
        step_d    = step_q + IDX_W'(1);
        if (in_window && (head_i == target_q)) begin
          hit_d = 1'b1;
        end
        if (pop_back_q && at_back) begin
          grab_d = head_i;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          res_load = 1'b1;
          if (pop_back_q) begin
            if (!empty) begin
              count_d      = count_q - CNT_W'(1);
              res_ok_d     = 1'b1;
              res_popped_d = grab_q;
            end
          end else begin
            res_found_d = hit_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    hit_q  <= hit_d;
    grab_q <= grab_d;
    if (accept) begin
      target_q   <= value_i;
      pop_back_q <= (kind_i == KIND_POP_BACK);
    end
    if (res_load) begin
      res_ok_q     <= res_ok_d;
      res_found_q  <= res_found_d;
      res_popped_q <= res_popped_d;
      res_occ_q    <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = res_ok_q;
  assign found_o     = res_found_q;
  assign popped_o    = res_popped_q;
  assign occ_o       = res_occ_q;
  assign count_o     = count_q;

endmodule
